>>> hdl/sri_pkg.sv
// shared types, widths and helpers for the segment / rectangle intersection block
// depends on nothing; used by segment_rect_intersect
package sri_pkg;

    localparam int COORD_BITS = 16;
    // differences of coordinates, including the far edges x+w and y+h
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    // one more bit for the difference of two products
    localparam int TERM_BITS  = PROD_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
        logic signed [COORD_BITS-1:0] rect_x;
        logic signed [COORD_BITS-1:0] rect_y;
        logic        [COORD_BITS-2:0] rect_w;
        logic        [COORD_BITS-2:0] rect_h;
    } sri_query_t;

    typedef struct packed {
        logic hit;
        logic hit_left;
        logic hit_right;
        logic hit_top;
        logic hit_bottom;
    } sri_result_t;

    typedef logic signed [DIFF_BITS-1:0] diff_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [TERM_BITS-1:0] term_t;

    function automatic diff_t sext_coord(logic [COORD_BITS-1:0] v);
        return {{(DIFF_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic diff_t zext_extent(logic [COORD_BITS-2:0] v);
        return {{(DIFF_BITS-COORD_BITS+1){1'b0}}, v};
    endfunction

    function automatic prod_t mul_diff(diff_t a, diff_t b);
        prod_t ae;
        prod_t be;
        ae = {{DIFF_BITS{a[DIFF_BITS-1]}}, a};
        be = {{DIFF_BITS{b[DIFF_BITS-1]}}, b};
        return prod_t'(ae * be);
    endfunction

    function automatic term_t sext_prod(prod_t v);
        return {v[PROD_BITS-1], v};
    endfunction

    // num/den lies in [0,1]; a zero denominator never does
    function automatic logic ratio_in_unit(term_t num, term_t den);
        logic r;
        if (den == '0)
            r = 1'b0;
        else if (!den[TERM_BITS-1])
            r = !num[TERM_BITS-1] && (num <= den);
        else
            r = (num[TERM_BITS-1] || (num == '0)) && (num >= den);
        return r;
    endfunction

endpackage

>>> hdl/segment_rect_intersect.sv
// segment against axis-aligned rectangle intersection test, four pipeline stages
// depends on sri_pkg (query / result structs, widths, multiply and compare helpers)
//
//  channel  | ports                     | transaction
//  ---------+---------------------------+-----------------------------------------
//  query    | start, busy, query        | taken at a clock edge with start & !busy
//  result   | done, result              | done high one cycle, cannot be held off
//
// one query enters per cycle; its result passes through the stage registers in order
// (differences, products, numerator terms, range compares: one register each)
// the ten 18x18 multipliers of the product stage set the depth of the pipe
// busy stays low: nothing downstream can push back, so nothing ever stalls
// reset clears the stage valid bits only, data registers are left as they are
module segment_rect_intersect
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sri_pkg::sri_query_t query,
    output logic                done,
    output sri_pkg::sri_result_t result
);

    // ------------------------------------------------------------------
    // stage 1: coordinate differences
    // each rectangle edge is axis aligned, so the general line/line test
    // collapses: vertical edges have den = h*dx, horizontal ones
    // den = w*(y1-y2); numerators below follow the same reduction
    // ------------------------------------------------------------------
    sri_pkg::diff_t x1, y1, x2, y2, rx, ry, rw, rh, rr, rb;

    always_comb
    begin
        x1 = sri_pkg::sext_coord(query.seg_start_x);
        y1 = sri_pkg::sext_coord(query.seg_start_y);
        x2 = sri_pkg::sext_coord(query.seg_end_x);
        y2 = sri_pkg::sext_coord(query.seg_end_y);
        rx = sri_pkg::sext_coord(query.rect_x);
        ry = sri_pkg::sext_coord(query.rect_y);
        rw = sri_pkg::zext_extent(query.rect_w);
        rh = sri_pkg::zext_extent(query.rect_h);
        // right and bottom edges, held two bits wider than a coordinate, never wrap
        rr = rx + rw;
        rb = ry + rh;
    end

    logic           v1_reg;
    sri_pkg::diff_t dx_reg, dy_reg, ndy_reg;
    sri_pkg::diff_t oxl_reg, oxr_reg, lxn_reg, rxn_reg, oyt_reg, oyb_reg;
    sri_pkg::diff_t w1_reg, h1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= x2 - x1;
        dy_reg  <= y2 - y1;
        ndy_reg <= y1 - y2;
        oxl_reg <= x1 - rx;     // segment start relative to left edge
        oxr_reg <= x1 - rr;     // ... to right edge
        lxn_reg <= rx - x1;
        rxn_reg <= rr - x1;
        oyt_reg <= y1 - ry;     // ... to top edge
        oyb_reg <= y1 - rb;     // ... to bottom edge
        w1_reg  <= rw;
        h1_reg  <= rh;
    end

    // ------------------------------------------------------------------
    // stage 2: products
    // denominators and the along-segment numerators are extent times
    // difference; the along-edge numerators need the cross products
    // ------------------------------------------------------------------
    logic           v2_reg;
    sri_pkg::prod_t den_v_reg, den_h_reg;
    sri_pkg::prod_t na_l_reg, na_r_reg, na_t_reg, na_b_reg;
    sri_pkg::prod_t p_xl_reg, p_xr_reg, p_yt_reg, p_yb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        den_v_reg <= sri_pkg::mul_diff(h1_reg, dx_reg);
        den_h_reg <= sri_pkg::mul_diff(w1_reg, ndy_reg);
        na_l_reg  <= sri_pkg::mul_diff(h1_reg, lxn_reg);
        na_r_reg  <= sri_pkg::mul_diff(h1_reg, rxn_reg);
        na_t_reg  <= sri_pkg::mul_diff(w1_reg, oyt_reg);
        na_b_reg  <= sri_pkg::mul_diff(w1_reg, oyb_reg);
        p_xl_reg  <= sri_pkg::mul_diff(dy_reg, oxl_reg);
        p_xr_reg  <= sri_pkg::mul_diff(dy_reg, oxr_reg);
        p_yt_reg  <= sri_pkg::mul_diff(dx_reg, oyt_reg);
        p_yb_reg  <= sri_pkg::mul_diff(dx_reg, oyb_reg);
    end

    // ------------------------------------------------------------------
    // stage 3: along-edge numerators, nb = dx*oy - dy*ox
    // left and top edges share the same corner, hence the same nb
    // ------------------------------------------------------------------
    logic           v3_reg;
    sri_pkg::term_t den_v3_reg, den_h3_reg;
    sri_pkg::term_t na_l3_reg, na_r3_reg, na_t3_reg, na_b3_reg;
    sri_pkg::term_t nb_lt_reg, nb_r_reg, nb_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        den_v3_reg <= sri_pkg::sext_prod(den_v_reg);
        den_h3_reg <= sri_pkg::sext_prod(den_h_reg);
        na_l3_reg  <= sri_pkg::sext_prod(na_l_reg);
        na_r3_reg  <= sri_pkg::sext_prod(na_r_reg);
        na_t3_reg  <= sri_pkg::sext_prod(na_t_reg);
        na_b3_reg  <= sri_pkg::sext_prod(na_b_reg);
        nb_lt_reg  <= sri_pkg::sext_prod(p_yt_reg) - sri_pkg::sext_prod(p_xl_reg);
        nb_r_reg   <= sri_pkg::sext_prod(p_yt_reg) - sri_pkg::sext_prod(p_xr_reg);
        nb_b_reg   <= sri_pkg::sext_prod(p_yb_reg) - sri_pkg::sext_prod(p_xl_reg);
    end

    // ------------------------------------------------------------------
    // stage 4: both parameters in [0,1], no division; sign-aware compare
    // of each numerator against its denominator, zero denominator misses
    // ------------------------------------------------------------------
    logic                 done_reg;
    sri_pkg::sri_result_t result_reg;
    sri_pkg::sri_result_t result_next;

    always_comb
    begin
        result_next.hit_left   = sri_pkg::ratio_in_unit(na_l3_reg, den_v3_reg)
                              && sri_pkg::ratio_in_unit(nb_lt_reg, den_v3_reg);
        result_next.hit_right  = sri_pkg::ratio_in_unit(na_r3_reg, den_v3_reg)
                              && sri_pkg::ratio_in_unit(nb_r_reg, den_v3_reg);
        result_next.hit_top    = sri_pkg::ratio_in_unit(na_t3_reg, den_h3_reg)
                              && sri_pkg::ratio_in_unit(nb_lt_reg, den_h3_reg);
        result_next.hit_bottom = sri_pkg::ratio_in_unit(na_b3_reg, den_h3_reg)
                              && sri_pkg::ratio_in_unit(nb_b_reg, den_h3_reg);
        result_next.hit        = result_next.hit_left || result_next.hit_right
                              || result_next.hit_top || result_next.hit_bottom;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // the pipe never holds, so a new transaction is always welcome
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
